/* hdl/kmm_pkg.sv */
`default_nettype none

package kmm_pkg;

   // parameter defaults
   localparam int PATTERN_MAX_DEFAULT   = 64;
   localparam int POSITION_BITS_DEFAULT = 20;

   // fixed field widths
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 6;
   localparam int CHAR_W  = 8;
   localparam int CSR_W   = 7;
   localparam int COUNT_W = 7;

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD  = 2'd0,
      MODE_START = 2'd1,
      MODE_TEXT  = 2'd2
   } mode_type;

   // register indexes
   localparam logic CSR_MISMATCH_LIMIT = 1'b0;
   localparam logic CSR_PATTERN_LENGTH = 1'b1;

   // per-cell control
   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
   } kmm_cell_ctrl_type;

endpackage

`default_nettype wire

/* hdl/kmm_cell.sv */
`default_nettype none

module kmm_cell import kmm_pkg::*; #(
   parameter int CNT_W = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kmm_cell_ctrl_type ctrl,
   input  wire logic [CHAR_W-1:0] char_in,
   input  wire logic [CNT_W-1:0]  prev_cnt,
   output logic      [CNT_W-1:0]  cnt,
   output logic      [CNT_W-1:0]  cnt_next
);

   logic [CHAR_W-1:0] pat_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              miss;

   // neighbor count plus this position's mismatch
   always_comb begin
      miss   = (pat_ff != char_in);
      cnt_in = prev_cnt + CNT_W'(miss);
   end

   // pattern byte, loaded by index
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pat_ff <= char_in;
      end
   end

   // partial mismatch count
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         cnt_ff <= '0;
      end else if (ctrl.shift) begin
         cnt_ff <= cnt_in;
      end
   end

   assign cnt      = cnt_ff;
   assign cnt_next = cnt_in;

endmodule

`default_nettype wire

/* hdl/k_mismatch_pattern_matcher_unit.sv */
// a text request that closes a window shows its response in the cycle after acceptance
// throughput: one request per cycle; every window alignment advances in its own cell at once
// the response register frees as it is taken, so a stalled response holds back requests
// reset clears the partial counts, byte count, position, limit (0) and length (1)
// pattern bytes are not cleared by reset and must be loaded before use
`default_nettype none

module k_mismatch_pattern_matcher_unit import kmm_pkg::*; #(
   parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [MODE_W-1:0]        req_mode,
   input  wire logic [INDEX_W-1:0]       req_pattern_index,
   input  wire logic [CHAR_W-1:0]        req_character,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic      [POSITION_BITS-1:0] rsp_window_start,
   output logic      [COUNT_W-1:0]       rsp_mismatch_count,
   output logic                          rsp_is_match,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [CSR_W-1:0]         csr_wdata
);

   localparam int CELL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CNT_W  = $clog2(PATTERN_MAX + 1);

   logic [CSR_W-1:0]         limit_ff;
   logic [CELL_W-1:0]        len_m1_ff;
   logic [CELL_W-1:0]        len_m1_in;
   logic [CNT_W-1:0]         seen_ff;
   logic [CNT_W-1:0]         seen_in;
   logic [POSITION_BITS-1:0] pos_ff;
   logic                     rsp_valid_ff;
   logic [POSITION_BITS-1:0] start_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic                     match_ff;

   logic                     req_fire;
   logic                     load_fire;
   logic                     start_fire;
   logic                     text_fire;
   logic                     out_free;
   logic                     emit;
   logic [CNT_W-1:0]         sel_cnt;
   logic [CNT_W+COUNT_W-1:0] cnt_pad;

   logic [CNT_W-1:0]         cell_cnt [PATTERN_MAX];
   logic [CNT_W-1:0]         cell_next [PATTERN_MAX];

   // request decode
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      req_ready  = out_free;
      req_fire   = req_valid && req_ready;
      load_fire  = req_fire && (req_mode == MODE_LOAD);
      start_fire = req_fire && (req_mode == MODE_START);
      text_fire  = req_fire && (req_mode == MODE_TEXT);
   end

   // chain of comparison cells
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      kmm_cell_ctrl_type ctrl;
      logic [CNT_W-1:0]  prev;

      assign ctrl.clear = start_fire;
      assign ctrl.load  = load_fire && (int'(req_pattern_index) == j);
      assign ctrl.shift = text_fire;

      if (j == 0) begin : g_head
         assign prev = '0;
      end else begin : g_link
         assign prev = cell_cnt[j-1];
      end

      kmm_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .char_in  (req_character),
         .prev_cnt (prev),
         .cnt      (cell_cnt[j]),
         .cnt_next (cell_next[j])
      );
   end

   // length register holds the clamped length minus one
   always_comb begin
      if (csr_wdata == '0) begin
         len_m1_in = '0;
      end else if (int'(csr_wdata) > PATTERN_MAX) begin
         len_m1_in = CELL_W'(PATTERN_MAX - 1);
      end else begin
         len_m1_in = CELL_W'(csr_wdata - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= '0;
         len_m1_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MISMATCH_LIMIT: limit_ff  <= csr_wdata;
            CSR_PATTERN_LENGTH: len_m1_ff <= len_m1_in;
            default:            limit_ff  <= limit_ff;
         endcase
      end
   end

   // saturating byte count and window pick
   always_comb begin
      if (int'(seen_ff) < PATTERN_MAX) begin
         seen_in = seen_ff + 1'b1;
      end else begin
         seen_in = seen_ff;
      end
      emit    = text_fire && (seen_in > CNT_W'(len_m1_ff));
      sel_cnt = cell_next[len_m1_ff];
      cnt_pad = (CNT_W + COUNT_W)'(sel_cnt);
   end

   // text history counters
   always_ff @(posedge clock) begin
      if (reset || start_fire) begin
         seen_ff <= '0;
         pos_ff  <= '0;
      end else if (text_fire) begin
         seen_ff <= seen_in;
         pos_ff  <= pos_ff + 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         start_ff <= pos_ff - POSITION_BITS'(len_m1_ff);
         count_ff <= cnt_pad[COUNT_W-1:0];
         match_ff <= (int'(sel_cnt) <= int'(limit_ff));
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_start   = start_ff;
   assign rsp_mismatch_count = count_ff;
   assign rsp_is_match       = match_ff;

   // a response appears only after a text request
   a_rsp_from_text: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(text_fire))
      else $error("response without text request");

   // start clears the text history
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start_fire |=> (seen_ff == '0) && (pos_ff == '0) && (cell_cnt[0] == '0))
      else $error("start did not clear history");

   // byte count saturates at the pattern depth
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      int'(seen_ff) <= PATTERN_MAX)
      else $error("byte count out of range");

   // a closing window is always delivered
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("closing window lost");

   // no response while the window is still short
   a_short_window: assert property (@(posedge clock) disable iff (reset)
      (text_fire && (seen_in <= CNT_W'(len_m1_ff))) |-> !emit)
      else $error("response before full window");

endmodule

`default_nettype wire

/* dv/tb_k_mismatch_pattern_matcher_unit.sv */
`default_nettype none

module tb_k_mismatch_pattern_matcher_unit import kmm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAT_MAX     = PATTERN_MAX_DEFAULT;
   localparam int POS_W       = POSITION_BITS_DEFAULT;
   localparam int SETTLE      = 4;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int REPORT_MAX  = 10;

   // mode with no function in the block
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0]   window_start;
      logic [COUNT_W-1:0] mismatch_count;
      logic               is_match;
   } window_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = MODE_START;
   logic [INDEX_W-1:0]  req_pattern_index = '0;
   logic [CHAR_W-1:0]   req_character = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [POS_W-1:0]    rsp_window_start;
   logic [COUNT_W-1:0]  rsp_mismatch_count;
   logic                rsp_is_match;
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_MISMATCH_LIMIT;
   logic [CSR_W-1:0]    csr_wdata = '0;

   // matcher state as the testbench tracks it
   logic [CHAR_W-1:0]   pattern_bytes [PAT_MAX];
   logic [COUNT_W-1:0]  partial_counts [PAT_MAX];
   int unsigned         text_bytes_seen = 0;
   logic [POS_W-1:0]    next_position = '0;
   logic [CSR_W-1:0]    limit_reg = 7'd0;
   logic [CSR_W-1:0]    length_reg = 7'd1;

   window_result_type   pending_windows [$];
   int unsigned         error_total = 0;
   int unsigned         cycle_count = 0;
   int unsigned         req_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;

   k_mismatch_pattern_matcher_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_pattern_index  (req_pattern_index),
      .req_character      (req_character),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_start   (rsp_window_start),
      .rsp_mismatch_count (rsp_mismatch_count),
      .rsp_is_match       (rsp_is_match),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // random backpressure on the response side
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic int unsigned effective_length();
      if (length_reg == 0) return 1;
      if (length_reg > PAT_MAX) return PAT_MAX;
      return length_reg;
   endfunction

   // advance the alignment chain and queue the window that closes
   task automatic update_window_counts(input logic [MODE_W-1:0] mode,
                                       input logic [INDEX_W-1:0] idx,
                                       input logic [CHAR_W-1:0] ch);
      int unsigned       span;
      window_result_type closed;
      case (mode)
         MODE_LOAD: begin
            pattern_bytes[idx] = ch;
         end
         MODE_START: begin
            foreach (partial_counts[j]) partial_counts[j] = '0;
            text_bytes_seen = 0;
            next_position = '0;
         end
         MODE_TEXT: begin
            for (int j = PAT_MAX - 1; j > 0; j--)
               partial_counts[j] = partial_counts[j-1] + COUNT_W'(pattern_bytes[j] != ch);
            partial_counts[0] = COUNT_W'(pattern_bytes[0] != ch);
            if (text_bytes_seen < PAT_MAX) text_bytes_seen++;
            span = effective_length();
            closed.window_start = next_position - POS_W'(span - 1);
            next_position = next_position + 1'b1;
            if (text_bytes_seen >= span) begin
               closed.mismatch_count = partial_counts[span-1];
               closed.is_match = (partial_counts[span-1] <= limit_reg);
               pending_windows.insert(pending_windows.size(), closed);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_error(input string msg);
      error_total++;
      if (error_total <= REPORT_MAX) $display("%s", msg);
   endtask

   // compare each response with the oldest expected window
   always @(posedge clock) begin : response_check
      window_result_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_windows.size() == 0) begin
            report_error($sformatf("unexpected response: start %0d count %0d match %0b",
                                   rsp_window_start, rsp_mismatch_count, rsp_is_match));
         end else begin
            want = pending_windows.pop_front();
            if (rsp_window_start !== want.window_start ||
                rsp_mismatch_count !== want.mismatch_count ||
                rsp_is_match !== want.is_match) begin
               report_error($sformatf(
                  "response: expected start %0d count %0d match %0b, got %0d %0d %0b",
                  want.window_start, want.mismatch_count, want.is_match,
                  rsp_window_start, rsp_mismatch_count, rsp_is_match));
            end
         end
      end
   end

   // one request through the handshake, with a random gap ahead of it
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [INDEX_W-1:0] idx,
                               input logic [CHAR_W-1:0] ch);
      int unsigned gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_pattern_index <= idx;
      req_character <= ch;
      do @(posedge clock); while (!req_ready);
      update_window_counts(mode, idx, ch);
   endtask

   task automatic send_text(input logic [CHAR_W-1:0] ch);
      send_request(MODE_TEXT, INDEX_W'($urandom), ch);
   endtask

   // hold off until every expected response is back and the block is quiet
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [CSR_W-1:0] value);
      wait_for_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_MISMATCH_LIMIT) limit_reg = value;
      else length_reg = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // every pattern slot gets a byte, extremes included
   task automatic load_pattern_test();
      for (int i = 0; i < PAT_MAX; i++) begin
         if (i == 0) send_request(MODE_LOAD, INDEX_W'(i), 8'h00);
         else if (i == PAT_MAX - 1) send_request(MODE_LOAD, INDEX_W'(i), 8'hFF);
         else send_request(MODE_LOAD, INDEX_W'(i), CHAR_W'($urandom));
      end
   endtask

   // reset configuration: length 1, limit 0
   task automatic reset_config_test();
      send_request(MODE_START, '0, '0);
      send_text(pattern_bytes[0]);
      send_text(~pattern_bytes[0]);
      send_text(8'h00);
      send_text(8'hFF);
   endtask

   // length and limit at and beyond their ends
   task automatic length_limit_extremes_test();
      write_register(CSR_PATTERN_LENGTH, 7'd0);
      write_register(CSR_MISMATCH_LIMIT, 7'd127);
      send_request(MODE_START, '1, '1);
      send_text(pattern_bytes[0]);
      send_text(~pattern_bytes[0]);
      // oversized length saturates, exact copy gives zero mismatches
      write_register(CSR_PATTERN_LENGTH, 7'd127);
      write_register(CSR_MISMATCH_LIMIT, 7'd0);
      send_request(MODE_START, '0, '0);
      for (int i = 0; i < PAT_MAX; i++) send_text(pattern_bytes[i]);
      // every byte differs
      write_register(CSR_PATTERN_LENGTH, 7'(PAT_MAX));
      write_register(CSR_MISMATCH_LIMIT, 7'(PAT_MAX));
      send_request(MODE_START, '0, '0);
      for (int i = 0; i < PAT_MAX; i++) send_text(~pattern_bytes[i]);
   endtask

   // text shorter than the pattern, reserved mode ignored
   task automatic short_text_test();
      write_register(CSR_PATTERN_LENGTH, 7'd5);
      write_register(CSR_MISMATCH_LIMIT, 7'd2);
      send_request(MODE_START, '0, '0);
      repeat (3) send_text(CHAR_W'($urandom));
      send_request(MODE_RESERVED, '1, '1);
      send_request(MODE_START, '0, '0);
      repeat (4) send_text(CHAR_W'($urandom));
      send_request(MODE_RESERVED, '0, '0);
      send_text(pattern_bytes[4]);
   endtask

   // length and pattern byte change while a text is running
   task automatic midtext_change_test();
      write_register(CSR_PATTERN_LENGTH, 7'd3);
      write_register(CSR_MISMATCH_LIMIT, 7'd1);
      send_request(MODE_START, '0, '0);
      for (int i = 0; i < 6; i++) send_text(pattern_bytes[i % 3]);
      write_register(CSR_PATTERN_LENGTH, 7'd6);
      for (int i = 0; i < 3; i++) send_text(pattern_bytes[i]);
      send_request(MODE_LOAD, 6'd2, CHAR_W'($urandom));
      for (int i = 0; i < 4; i++) send_text(pattern_bytes[i]);
   endtask

   // mostly texts close to the pattern, some noise
   task automatic random_traffic_test(input int unsigned n_items);
      int unsigned         sent, run_len, span, pick;
      logic [CSR_W-1:0]    new_length;
      logic [MODE_W-1:0]   mode;
      logic [CHAR_W-1:0]   ch;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 85) begin
            if ($urandom_range(99) < 30) begin
               pick = $urandom_range(9);
               if (pick < 6) new_length = CSR_W'($urandom_range(8, 1));
               else if (pick < 8) new_length = CSR_W'($urandom_range(PAT_MAX, 9));
               else if (pick == 8) new_length = '0;
               else new_length = CSR_W'($urandom_range(127, PAT_MAX + 1));
               write_register(CSR_PATTERN_LENGTH, new_length);
               if ($urandom_range(99) < 10) write_register(CSR_MISMATCH_LIMIT, 7'd127);
               else write_register(CSR_MISMATCH_LIMIT,
                                   CSR_W'($urandom_range(effective_length() + 1, 0)));
            end
            if ($urandom_range(99) < 70) begin
               send_request(MODE_START, INDEX_W'($urandom), CHAR_W'($urandom));
               sent++;
            end
            run_len = $urandom_range(40, 1);
            span = effective_length();
            for (int o = 0; o < run_len; o++) begin
               if ($urandom_range(99) < 4) begin
                  send_request(MODE_LOAD, INDEX_W'($urandom), CHAR_W'($urandom));
                  sent++;
               end else if ($urandom_range(99) < 2) begin
                  send_request(MODE_RESERVED, INDEX_W'($urandom), CHAR_W'($urandom));
               end else begin
                  ch = ($urandom_range(99) < 80) ? pattern_bytes[o % span] : CHAR_W'($urandom);
                  send_text(ch);
                  sent++;
               end
            end
         end else begin
            repeat ($urandom_range(6, 1)) begin
               mode = MODE_W'($urandom);
               send_request(mode, INDEX_W'($urandom), CHAR_W'($urandom));
               if (mode != MODE_RESERVED) sent++;
            end
         end
      end
   endtask

   initial begin
      foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
      foreach (partial_counts[i]) partial_counts[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver stalls heavily
      req_idle_pct = 32;
      rsp_stall_pct = 82;
      load_pattern_test();
      reset_config_test();
      length_limit_extremes_test();
      short_text_test();
      midtext_change_test();
      random_traffic_test(190);

      // the other way round
      req_idle_pct = 82;
      rsp_stall_pct = 32;
      random_traffic_test(190);

      // full rate
      wait_for_idle();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      random_traffic_test(190);

      wait_for_idle();
      if (error_total == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hdl/kmm_pkg.sv
hdl/kmm_cell.sv
hdl/k_mismatch_pattern_matcher_unit.sv
dv/tb_k_mismatch_pattern_matcher_unit.sv
